@@ rtl/core/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescape unit.
// Used by jsu_decode and json_string_unescape_utf8_unit; no dependencies.
`default_nettype none

package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_UNTERM_ESCAPE = 3'd1,
    ERR_TRUNC_UNICODE = 3'd2,
    ERR_BAD_UNICODE   = 3'd3,
    ERR_BAD_ESCAPE    = 3'd4,
    ERR_UNTERM_STRING = 3'd5
  } err_e;

  // UTF-8 encoding limits and marks
  localparam logic [15:0] CP_ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2        = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3        = 8'hE0;
  localparam logic [7:0]  UTF8_CONT         = 8'h80;
  localparam logic [5:0]  UTF8_CONT_MASK    = 6'h3F;

  localparam int unsigned MAX_BURST = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    err_e       error_code;
    logic       last;
  } result_t;

  // Results caused by one input word, item[0] first
  typedef struct packed {
    logic [1:0]              count;
    result_t [MAX_BURST-1:0] item;
  } burst_t;

endpackage

`default_nettype wire

@@ rtl/core/json_string_unescape_utf8_unit.sv @@
// JSON string body unescaper with UTF-8 encoding of \uXXXX escapes.
// The input channel takes one text byte (or an end-of-text mark) per word;
// the output channel gives decoded bytes, a string-closed mark or an error.
// Each word may cause zero to three results; last flags the final one.
// Each result is registered into the result queue and shown from its front.
// One input word is taken per cycle while each word yields at most one
// result and the output is not stalled; a \u escape that encodes to two or
// three bytes stalls the input while the single output port drains a
// four-entry result queue one entry per cycle while not stalled.
// in_stall_o is high while more than one result waits in the queue, so a
// new word is taken while one finished result still waits to be taken.
// out_stall_i holds the front result stable; input stalls once it backs up.
// After a close or an error the unit ignores bytes until a quote opens
// the next string.
// Reset clears the scan state to normal character mode and empties the queue.
// Depends on jsu_pkg and jsu_decode.
`default_nettype none

module json_string_unescape_utf8_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       text_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      kind_o,
  output logic [2:0]      error_code_o,
  output logic            last_o
);

  localparam int unsigned QDepth = 4;

  logic [2:0]          count_q, count_d;
  jsu_pkg::result_t    slot_q [QDepth];
  jsu_pkg::result_t    slot_d [QDepth];
  jsu_pkg::burst_t     burst;
  logic                take, pop;
  logic [2:0]          base;

  assign in_stall_o  = count_q > 3'd1;
  assign out_valid_o = count_q != 3'd0;
  assign take        = in_valid_i & ~in_stall_o;
  assign pop         = out_valid_o & ~out_stall_i;

  jsu_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .in_byte_i  (in_byte_i),
    .text_end_i (text_end_i),
    .burst_o    (burst)
  );

  assign base = count_q - {2'b00, pop};

  always_comb begin
    slot_d = slot_q;
    // advance the queue on a pop
    if (pop) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
    end
    // append the new burst behind what remains
    if (take) begin
      for (int k = 0; k < jsu_pkg::MAX_BURST; k++) begin
        if (2'(k) < burst.count) begin
          slot_d[base[1:0] + 2'(k)] = burst.item[k];
        end
      end
    end
    count_d = base + (take ? {1'b0, burst.count} : 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign out_byte_o   = slot_q[0].out_byte;
  assign kind_o       = slot_q[0].kind;
  assign error_code_o = slot_q[0].error_code;
  assign last_o       = slot_q[0].last;

endmodule

`default_nettype wire

@@ rtl/core/jsu_decode.sv @@
// Scan state and per-byte decode for the JSON string unescape unit.
// Depends on jsu_pkg; produces up to three results for each accepted word.
`default_nettype none

module jsu_decode (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            text_end_i,
  output jsu_pkg::burst_t      burst_o
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2,
    MODE_IDLE   = 2'd3
  } mode_e;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;

  mode_e       mode_q, mode_d;
  logic [1:0]  seen_q, seen_d;
  logic [15:0] cp_q, cp_d;
  logic        bad_q, bad_d;

  logic        digit_ok;
  logic [3:0]  digit;
  logic [15:0] cp_shift;
  jsu_pkg::burst_t burst;

  // hex digit of either case
  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'h0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      digit = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      digit = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      digit = 4'(in_byte_i - 8'h37);
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign cp_shift = {cp_q[11:0], digit};

  always_comb begin
    mode_d = mode_q;
    seen_d = seen_q;
    cp_d   = cp_q;
    bad_d  = bad_q;
    burst  = '0;
    for (int k = 0; k < jsu_pkg::MAX_BURST; k++) begin
      burst.item[k].kind       = jsu_pkg::KIND_DATA;
      burst.item[k].error_code = jsu_pkg::ERR_NONE;
    end

    unique case (mode_q)
      MODE_NORMAL: begin
        if (text_end_i) begin
          mode_d = MODE_IDLE;
          burst.count = 2'd1;
          burst.item[0].kind       = jsu_pkg::KIND_ERROR;
          burst.item[0].error_code = jsu_pkg::ERR_UNTERM_STRING;
        end else if (in_byte_i == CH_QUOTE) begin
          mode_d = MODE_IDLE;
          burst.count = 2'd1;
          burst.item[0].kind = jsu_pkg::KIND_CLOSED;
        end else if (in_byte_i == CH_BACKSLASH) begin
          mode_d = MODE_ESCAPE;
        end else begin
          burst.count = 2'd1;
          burst.item[0].out_byte = in_byte_i;
        end
      end

      MODE_ESCAPE: begin
        if (text_end_i) begin
          mode_d = MODE_IDLE;
          burst.count = 2'd1;
          burst.item[0].kind       = jsu_pkg::KIND_ERROR;
          burst.item[0].error_code = jsu_pkg::ERR_UNTERM_ESCAPE;
        end else begin
          mode_d = MODE_NORMAL;
          burst.count = 2'd1;
          unique case (in_byte_i)
            CH_QUOTE:     burst.item[0].out_byte = CH_QUOTE;
            CH_BACKSLASH: burst.item[0].out_byte = CH_BACKSLASH;
            CH_SLASH:     burst.item[0].out_byte = CH_SLASH;
            CH_B:         burst.item[0].out_byte = CH_BS;
            CH_F:         burst.item[0].out_byte = CH_FF;
            CH_N:         burst.item[0].out_byte = CH_LF;
            CH_R:         burst.item[0].out_byte = CH_CR;
            CH_T:         burst.item[0].out_byte = CH_TAB;
            CH_U: begin
              mode_d      = MODE_HEX;
              seen_d      = 2'd0;
              cp_d        = '0;
              bad_d       = 1'b0;
              burst.count = 2'd0;
            end
            default: begin
              mode_d = MODE_IDLE;
              burst.item[0].kind       = jsu_pkg::KIND_ERROR;
              burst.item[0].error_code = jsu_pkg::ERR_BAD_ESCAPE;
            end
          endcase
        end
      end

      MODE_HEX: begin
        if (text_end_i) begin
          // truncation wins over a pending bad digit
          mode_d = MODE_IDLE;
          burst.count = 2'd1;
          burst.item[0].kind       = jsu_pkg::KIND_ERROR;
          burst.item[0].error_code = jsu_pkg::ERR_TRUNC_UNICODE;
        end else begin
          cp_d  = cp_shift;
          bad_d = bad_q | ~digit_ok;
          if (seen_q != 2'd3) begin
            seen_d = seen_q + 2'd1;
          end else begin
            seen_d = 2'd0;
            if (bad_q || !digit_ok) begin
              bad_d  = 1'b0;
              mode_d = MODE_IDLE;
              burst.count = 2'd1;
              burst.item[0].kind       = jsu_pkg::KIND_ERROR;
              burst.item[0].error_code = jsu_pkg::ERR_BAD_UNICODE;
            end else begin
              mode_d = MODE_NORMAL;
              if (cp_shift < jsu_pkg::CP_ONE_BYTE_LIMIT) begin
                burst.count = 2'd1;
                burst.item[0].out_byte = cp_shift[7:0];
              end else if (cp_shift < jsu_pkg::CP_TWO_BYTE_LIMIT) begin
                burst.count = 2'd2;
                burst.item[0].out_byte = jsu_pkg::UTF8_LEAD2 | {3'b000, cp_shift[10:6]};
                burst.item[1].out_byte = jsu_pkg::UTF8_CONT
                                         | {2'b00, cp_shift[5:0] & jsu_pkg::UTF8_CONT_MASK};
              end else begin
                burst.count = 2'd3;
                burst.item[0].out_byte = jsu_pkg::UTF8_LEAD3 | {4'h0, cp_shift[15:12]};
                burst.item[1].out_byte = jsu_pkg::UTF8_CONT
                                         | {2'b00, cp_shift[11:6] & jsu_pkg::UTF8_CONT_MASK};
                burst.item[2].out_byte = jsu_pkg::UTF8_CONT
                                         | {2'b00, cp_shift[5:0] & jsu_pkg::UTF8_CONT_MASK};
              end
            end
          end
        end
      end

      MODE_IDLE: begin
        // wait for the opening quote of the next string
        if (!text_end_i && in_byte_i == CH_QUOTE) begin
          mode_d = MODE_NORMAL;
          seen_d = 2'd0;
          cp_d   = '0;
          bad_d  = 1'b0;
        end
      end

      default: mode_d = MODE_IDLE;
    endcase

    // mark the final result of this word
    unique case (burst.count)
      2'd1:    burst.item[0].last = 1'b1;
      2'd2:    burst.item[1].last = 1'b1;
      2'd3:    burst.item[2].last = 1'b1;
      default: ;
    endcase
  end

  assign burst_o = burst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      seen_q <= 2'd0;
      cp_q   <= '0;
      bad_q  <= 1'b0;
    end else if (take_i) begin
      mode_q <= mode_d;
      seen_q <= seen_d;
      cp_q   <= cp_d;
      bad_q  <= bad_d;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_json_string_unescape_utf8_unit.sv @@
`timescale 1ns / 1ps
// Self-checking bench for json_string_unescape_utf8_unit: escapes, \u UTF-8 bursts, errors.
// Depends on jsu_pkg and the unit; decoded words are predicted here and compared in order.

module tb_json_string_unescape_utf8_unit;

  localparam int unsigned RAND_WORDS   = 350;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned DIR_ROWS     = 31;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ESC_B  = "b";
  localparam logic [7:0] CH_ESC_F  = "f";
  localparam logic [7:0] CH_ESC_N  = "n";
  localparam logic [7:0] CH_ESC_R  = "r";
  localparam logic [7:0] CH_ESC_T  = "t";
  localparam logic [7:0] CH_ESC_U  = "u";
  localparam logic [7:0] CTRL_BS   = 8'h08;
  localparam logic [7:0] CTRL_FF   = 8'h0C;
  localparam logic [7:0] CTRL_LF   = 8'h0A;
  localparam logic [7:0] CTRL_CR   = 8'h0D;
  localparam logic [7:0] CTRL_TAB  = 8'h09;

  localparam logic [63:0] ESC_LETTERS = {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_ESC_B,
                                         CH_ESC_F, CH_ESC_N, CH_ESC_R, CH_ESC_T};
  localparam logic [95:0] EDGE_CPS = {16'h0000, 16'h007F, 16'h0080,
                                      16'h07FF, 16'h0800, 16'hFFFF};

  typedef enum logic [1:0] {SCAN_TEXT, SCAN_ESC, SCAN_HEX, SCAN_IDLE} scan_e;
  typedef enum logic [1:0] {CHK_PRED, CHK_ONE, CHK_NONE} chk_e;

  typedef struct packed {
    logic [7:0]     in_b;
    logic           fin;
    chk_e           chk;
    jsu_pkg::kind_e kind;
    jsu_pkg::err_e  err;
    logic [7:0]     ob;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       text_end_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;
  logic [2:0] error_code_o;
  logic       last_o;

  // predictor state
  scan_e       scan_mode;
  logic [1:0]  hex_seen;
  logic [15:0] code_pt;
  logic        bad_hex;

  jsu_pkg::result_t decoded_q[$];
  int unsigned      fail_cnt = 0;
  int unsigned      cycle_cnt;
  logic             calm = 1'b0;
  logic [15:0]      target_cp;

  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{8'h00,     1'b0, CHK_ONE,  jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{8'hFF,     1'b0, CHK_ONE,  jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'hFF},
    '{CH_BSLASH, 1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{CH_ESC_U,  1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{"F",       1'b0, CHK_PRED, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{"f",       1'b0, CHK_PRED, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{"f",       1'b0, CHK_PRED, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{"F",       1'b0, CHK_PRED, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{CH_BSLASH, 1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{CH_ESC_U,  1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{"g",       1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{"0",       1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{"0",       1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{"0",       1'b0, CHK_ONE,  jsu_pkg::KIND_ERROR,  jsu_pkg::ERR_BAD_UNICODE,   8'h00},
    '{8'h41,     1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{8'hFF,     1'b1, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{CH_QUOTE,  1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{CH_BSLASH, 1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{"x",       1'b0, CHK_ONE,  jsu_pkg::KIND_ERROR,  jsu_pkg::ERR_BAD_ESCAPE,    8'h00},
    '{CH_QUOTE,  1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{CH_BSLASH, 1'b1, CHK_ONE,  jsu_pkg::KIND_ERROR,  jsu_pkg::ERR_UNTERM_STRING, 8'h00},
    '{CH_QUOTE,  1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{CH_QUOTE,  1'b0, CHK_ONE,  jsu_pkg::KIND_CLOSED, jsu_pkg::ERR_NONE,          8'h00},
    '{CH_QUOTE,  1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{CH_BSLASH, 1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{8'h00,     1'b1, CHK_ONE,  jsu_pkg::KIND_ERROR,  jsu_pkg::ERR_UNTERM_ESCAPE, 8'h00},
    '{CH_QUOTE,  1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{CH_BSLASH, 1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{CH_ESC_U,  1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{"z",       1'b0, CHK_NONE, jsu_pkg::KIND_DATA,   jsu_pkg::ERR_NONE,          8'h00},
    '{8'h00,     1'b1, CHK_ONE,  jsu_pkg::KIND_ERROR,  jsu_pkg::ERR_TRUNC_UNICODE, 8'h00}
  };

  json_string_unescape_utf8_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .text_end_i  (text_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .kind_o      (kind_o),
    .error_code_o(error_code_o),
    .last_o      (last_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void emit(inout jsu_pkg::burst_t r, input logic [7:0] b,
                               input jsu_pkg::kind_e k, input jsu_pkg::err_e e);
    r.item[r.count] = '{out_byte: b, kind: k, error_code: e, last: 1'b0};
    r.count++;
  endfunction

  // Advance the predictor by one word and return the decoded words it causes.
  function automatic jsu_pkg::burst_t decode_word(logic [7:0] b, logic fin);
    jsu_pkg::burst_t r;
    logic [3:0] nib;
    r = '0;
    case (scan_mode)
      SCAN_TEXT: begin
        if (fin) begin
          emit(r, 8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERM_STRING);
          scan_mode = SCAN_IDLE;
        end else if (b == CH_QUOTE) begin
          emit(r, 8'h00, jsu_pkg::KIND_CLOSED, jsu_pkg::ERR_NONE);
          scan_mode = SCAN_IDLE;
        end else if (b == CH_BSLASH) begin
          scan_mode = SCAN_ESC;
        end else begin
          emit(r, b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
      end
      SCAN_ESC: begin
        if (fin) begin
          emit(r, 8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERM_ESCAPE);
          scan_mode = SCAN_IDLE;
        end else begin
          scan_mode = SCAN_TEXT;
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: emit(r, b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            CH_ESC_B: emit(r, CTRL_BS, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            CH_ESC_F: emit(r, CTRL_FF, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            CH_ESC_N: emit(r, CTRL_LF, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            CH_ESC_R: emit(r, CTRL_CR, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            CH_ESC_T: emit(r, CTRL_TAB, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            CH_ESC_U: begin
              scan_mode = SCAN_HEX;
              hex_seen  = 2'd0;
              code_pt   = 16'h0000;
              bad_hex   = 1'b0;
            end
            default: begin
              emit(r, 8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_ESCAPE);
              scan_mode = SCAN_IDLE;
            end
          endcase
        end
      end
      SCAN_HEX: begin
        if (fin) begin
          // truncation wins over a held bad digit
          emit(r, 8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_TRUNC_UNICODE);
          scan_mode = SCAN_IDLE;
        end else begin
          nib = 4'h0;
          if (b >= "0" && b <= "9") nib = 4'(b - "0");
          else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
          else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
          else bad_hex = 1'b1;
          code_pt = {code_pt[11:0], nib};
          if (hex_seen != 2'd3) begin
            hex_seen++;
          end else begin
            hex_seen = 2'd0;
            if (bad_hex) begin
              bad_hex = 1'b0;
              emit(r, 8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_UNICODE);
              scan_mode = SCAN_IDLE;
            end else begin
              scan_mode = SCAN_TEXT;
              if (code_pt < jsu_pkg::CP_ONE_BYTE_LIMIT) begin
                emit(r, code_pt[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
              end else if (code_pt < jsu_pkg::CP_TWO_BYTE_LIMIT) begin
                emit(r, jsu_pkg::UTF8_LEAD2 | {3'b000, code_pt[10:6]},
                     jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                emit(r, jsu_pkg::UTF8_CONT | {2'b00, code_pt[5:0] & jsu_pkg::UTF8_CONT_MASK},
                     jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
              end else begin
                emit(r, jsu_pkg::UTF8_LEAD3 | {4'h0, code_pt[15:12]},
                     jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                emit(r, jsu_pkg::UTF8_CONT | {2'b00, code_pt[11:6]},
                     jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                emit(r, jsu_pkg::UTF8_CONT | {2'b00, code_pt[5:0]},
                     jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
              end
            end
          end
        end
      end
      default: begin
        // idle: only an opening quote matters
        if (!fin && b == CH_QUOTE) begin
          scan_mode = SCAN_TEXT;
          hex_seen  = 2'd0;
          code_pt   = 16'h0000;
          bad_hex   = 1'b0;
        end
      end
    endcase
    if (r.count != 2'd0) r.item[r.count - 1].last = 1'b1;
    return r;
  endfunction

  task automatic queue_word(jsu_pkg::result_t w);
    decoded_q = {decoded_q, w};
  endtask

  task automatic push_burst(jsu_pkg::burst_t r);
    for (int i = 0; i < int'(r.count); i++) queue_word(r.item[i]);
  endtask

  // Present one word from a falling edge; return at the rising edge that takes it.
  task automatic send_word(logic [7:0] b, logic fin);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    text_end_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic show_mismatch(string field, logic [7:0] want_v, logic [7:0] got_v);
    fail_cnt++;
    $display("%0t: %s expected %h actual %h", $time, field, want_v, got_v);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 12);
  end

  always @(posedge clk_i) begin
    jsu_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: expected no word, actual byte %h kind %0d error %0d last %0b",
                 $time, out_byte_o, kind_o, error_code_o, last_o);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.out_byte) show_mismatch("out_byte", want.out_byte, out_byte_o);
        if (kind_o !== want.kind) show_mismatch("kind", want.kind, kind_o);
        if (error_code_o !== want.error_code)
          show_mismatch("error_code", want.error_code, error_code_o);
        if (last_o !== want.last) show_mismatch("last", want.last, last_o);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    dir_row_t    row;
    int unsigned sent;
    int unsigned pick;
    int unsigned r;
    logic [7:0]  b;
    logic        fin;
    logic        counts;
    logic [3:0]  nib;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i  = 8'h00;
    text_end_i = 1'b0;
    scan_mode  = SCAN_TEXT;
    hex_seen   = 2'd0;
    code_pt    = 16'h0000;
    bad_hex    = 1'b0;
    target_cp  = 16'h0000;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_tbl[i];
      send_word(row.in_b, row.fin);
      case (row.chk)
        CHK_PRED: push_burst(decode_word(row.in_b, row.fin));
        CHK_ONE: begin
          void'(decode_word(row.in_b, row.fin));
          queue_word('{out_byte: row.ob, kind: row.kind, error_code: row.err,
                       last: 1'b1});
        end
        default: void'(decode_word(row.in_b, row.fin));
      endcase
    end

    sent = 0;
    while (sent < RAND_WORDS) begin
      calm = (sent >= 120 && sent < 200);
      fin  = 1'b0;
      b    = 8'($urandom_range(0, 255));
      r    = $urandom_range(0, 99);
      case (scan_mode)
        SCAN_TEXT: begin
          if (r < 18) b = CH_BSLASH;
          else if (r < 26) b = CH_QUOTE;
          else if (r < 29) fin = 1'b1;
          else if (r < 60) b = 8'($urandom_range(8'h20, 8'h7E));
        end
        SCAN_ESC: begin
          if (r < 85) begin
            pick = $urandom_range(0, 11);
            b = (pick >= 8) ? CH_ESC_U : ESC_LETTERS[8*pick +: 8];
          end else if (r >= 95) begin
            fin = 1'b1;
          end
        end
        SCAN_HEX: begin
          // aim each escape at one UTF-8 length class, edges included
          if (hex_seen == 2'd0) begin
            case ($urandom_range(0, 3))
              0: target_cp = 16'($urandom_range(16'h0000, 16'h007F));
              1: target_cp = 16'($urandom_range(16'h0080, 16'h07FF));
              2: target_cp = 16'($urandom_range(16'h0800, 16'hFFFF));
              default: target_cp = EDGE_CPS[16*$urandom_range(0, 5) +: 16];
            endcase
          end
          if (r < 90) begin
            nib = target_cp[4*(3 - hex_seen) +: 4];
            if (nib < 4'd10) b = "0" + {4'h0, nib};
            else b = ($urandom_range(0, 1) ? "A" : "a") + {4'h0, nib} - 8'd10;
          end else if (r >= 96) begin
            fin = 1'b1;
          end
        end
        default: begin
          if (r < 85) b = CH_QUOTE;
          else if (r >= 93) fin = 1'b1;
        end
      endcase
      // idle noise is dropped by the unit; do not count it
      counts = !(scan_mode == SCAN_IDLE && (fin || b != CH_QUOTE));
      send_word(b, fin);
      push_burst(decode_word(b, fin));
      if (counts) sent++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
